/* src/icf_pkg.sv */
// Package for the integer constant-fold ALU: request and response words,
// queue entry, opcode codes and shared constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package icf_pkg;

	localparam int SYMBOL_ID_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int DIV_STEPS = 64;

	localparam logic [63:0] LOW32 = 64'h0000_0000_ffff_ffff;
	localparam logic [63:0] SMIN64 = 64'h8000_0000_0000_0000;
	localparam logic [31:0] SMIN32 = 32'h8000_0000;

	localparam logic [4:0] OP_ADD   = 5'd0;
	localparam logic [4:0] OP_SUB   = 5'd1;
	localparam logic [4:0] OP_NEG   = 5'd2;
	localparam logic [4:0] OP_DIV   = 5'd3;
	localparam logic [4:0] OP_REM   = 5'd4;
	localparam logic [4:0] OP_UDIV  = 5'd5;
	localparam logic [4:0] OP_UREM  = 5'd6;
	localparam logic [4:0] OP_MUL   = 5'd7;
	localparam logic [4:0] OP_AND   = 5'd8;
	localparam logic [4:0] OP_OR    = 5'd9;
	localparam logic [4:0] OP_XOR   = 5'd10;
	localparam logic [4:0] OP_SAR   = 5'd11;
	localparam logic [4:0] OP_SHR   = 5'd12;
	localparam logic [4:0] OP_SHL   = 5'd13;
	localparam logic [4:0] OP_EXTSB = 5'd14;
	localparam logic [4:0] OP_EXTUB = 5'd15;
	localparam logic [4:0] OP_EXTSH = 5'd16;
	localparam logic [4:0] OP_EXTUH = 5'd17;
	localparam logic [4:0] OP_EXTSW = 5'd18;
	localparam logic [4:0] OP_EXTUW = 5'd19;
	localparam logic [4:0] OP_CAST  = 5'd20;
	localparam logic [4:0] OP_CEQ   = 5'd21;
	localparam logic [4:0] OP_CNE   = 5'd22;
	localparam logic [4:0] OP_CSGE  = 5'd23;
	localparam logic [4:0] OP_CSGT  = 5'd24;
	localparam logic [4:0] OP_CSLE  = 5'd25;
	localparam logic [4:0] OP_CSLT  = 5'd26;
	localparam logic [4:0] OP_CUGE  = 5'd27;
	localparam logic [4:0] OP_CUGT  = 5'd28;
	localparam logic [4:0] OP_CULE  = 5'd29;
	localparam logic [4:0] OP_CULT  = 5'd30;
	localparam logic [4:0] OP_NONE  = 5'd31;

	typedef struct packed {
		logic [4:0]  mode;
		logic        wide;
		logic        compare_long;
		logic [63:0] left_value;
		logic [63:0] right_value;
		logic        left_is_addr;
		logic        right_is_addr;
		logic [31:0] left_symbol;
		logic [31:0] right_symbol;
	} req_t;

	typedef struct packed {
		logic        cannot_fold;
		logic [63:0] result_value;
		logic        result_is_addr;
		logic [31:0] result_symbol;
	} rsp_t;

	// classified word between front and back; for divides l and r hold magnitudes
	typedef struct packed {
		logic        fail;
		logic [4:0]  mode;
		logic        wide;
		logic        cmp_long;
		logic [63:0] l;
		logic [63:0] r;
		logic        neg_q;
		logic        neg_r;
		logic        raddr;
		logic [31:0] rsym;
	} ent_t;

	typedef enum logic [1:0] {
		BK_RUN,
		BK_MUL,
		BK_DIV,
		BK_DONE
	} bk_state_t;

	function automatic logic [63:0] sext32(input logic [63:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

endpackage
`default_nettype wire

/* src/icf_front.sv */
// Front part: applies the address rules, catches divide by zero and signed
// overflow, and prepares divide magnitudes. Uses icf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module icf_front import icf_pkg::*; #(
	parameter int SYMBOL_ID_BITS = SYMBOL_ID_BITS_DEF
) (
	input  req_t req,
	output ent_t ent
);

	localparam int SymW = (SYMBOL_ID_BITS < 32) ? SYMBOL_ID_BITS : 32;
	localparam logic [31:0] SymMask = 32'((64'd1 << SymW) - 64'd1);

	logic [31:0] ls, rs;
	logic        la, ra, w;
	logic        fail, raddr;
	logic [31:0] rsym;
	logic        r_zero, r_m1, l_min, is_div, is_sdiv;
	logic [63:0] sa, sb, ua, ub;

	always_comb begin
		ls = req.left_symbol & SymMask;
		rs = req.right_symbol & SymMask;
		la = req.left_is_addr;
		ra = req.right_is_addr;
		w = req.wide;
		fail = 1'b0;
		raddr = 1'b0;
		rsym = '0;
		case (req.mode)
			OP_ADD: begin
				if (la && ra) begin
					fail = 1'b1;
				end else if (la) begin
					raddr = 1'b1;
					rsym = ls;
				end else if (ra) begin
					raddr = 1'b1;
					rsym = rs;
				end
			end
			OP_SUB: begin
				if (la) begin
					if (!ra) begin
						raddr = 1'b1;
						rsym = ls;
					end else if (ls != rs) begin
						fail = 1'b1;
					end
				end else if (ra) begin
					fail = 1'b1;
				end
			end
			OP_NONE: fail = 1'b1;
			default: fail = la || ra;
		endcase

		r_zero = w ? (req.right_value == '0) : (req.right_value[31:0] == '0);
		r_m1 = w ? (req.right_value == '1) : (req.right_value[31:0] == '1);
		l_min = w ? (req.left_value == SMIN64) : (req.left_value[31:0] == SMIN32);
		is_sdiv = (req.mode == OP_DIV) || (req.mode == OP_REM);
		is_div = is_sdiv || (req.mode == OP_UDIV) || (req.mode == OP_UREM);
		if (is_div && (r_zero || (is_sdiv && r_m1 && l_min))) begin
			fail = 1'b1;
		end

		// signed operands at the operation width, then magnitudes
		sa = w ? req.left_value : sext32(req.left_value);
		sb = w ? req.right_value : sext32(req.right_value);
		ua = is_sdiv ? (sa[63] ? 64'd0 - sa : sa) : (w ? req.left_value : req.left_value & LOW32);
		ub = is_sdiv ? (sb[63] ? 64'd0 - sb : sb) : (w ? req.right_value : req.right_value & LOW32);

		ent.fail = fail;
		ent.mode = req.mode;
		ent.wide = w;
		ent.cmp_long = req.compare_long;
		ent.l = is_div ? ua : req.left_value;
		ent.r = is_div ? ub : req.right_value;
		ent.neg_q = is_sdiv && (sa[63] ^ sb[63]);
		ent.neg_r = is_sdiv && sa[63];
		ent.raddr = raddr && !fail;
		ent.rsym = (raddr && !fail) ? rsym : '0;
	end

endmodule
`default_nettype wire

/* src/icf_queue.sv */
// Short queue of classified words between front and back.
// Uses icf_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module icf_queue import icf_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ent_t wdata,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output ent_t rdata
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	ent_t mem_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CntFull);
	assign nonempty = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && nonempty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/icf_back.sv */
// Back part: combinational logic ops, registered split multiplier, iterative
// radix-2 divider, and the response register. Uses icf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module icf_back import icf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  ent_t head,
	output logic pop,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CntW = $clog2(DIV_STEPS + 1);

	bk_state_t state_q, state_d;
	logic out_free, load_out, load_mul, load_div;
	rsp_t out_d, out_q;
	logic out_valid_q;

	logic [63:0] mul_lo_q;
	logic [31:0] mul_x1_q, mul_x2_q;
	logic        mul_wide_q;
	logic [63:0] mul_res;

	logic [63:0] rem_q, quo_q, dvs_q;
	logic [CntW-1:0] cnt_q;
	logic        div_rem_q, div_negq_q, div_negr_q, div_wide_q;
	logic [64:0] trial;
	logic [63:0] div_res;

	logic [63:0] x, a, b, src;
	logic [5:0]  sh;
	logic        c;
	logic        is_mul, is_div;
	rsp_t simple;

	// combinational result of the head word
	always_comb begin
		sh = head.wide ? head.r[5:0] : {1'b0, head.r[4:0]};
		a = head.cmp_long ? head.l : sext32(head.l);
		b = head.cmp_long ? head.r : sext32(head.r);
		src = head.wide ? head.l : sext32(head.l);
		c = 1'b0;
		case (head.mode)
			OP_CEQ:  c = (a == b);
			OP_CNE:  c = (a != b);
			OP_CSGE: c = !($signed(a) < $signed(b));
			OP_CSGT: c = ($signed(b) < $signed(a));
			OP_CSLE: c = !($signed(b) < $signed(a));
			OP_CSLT: c = ($signed(a) < $signed(b));
			OP_CUGE: c = (a >= b);
			OP_CUGT: c = (a > b);
			OP_CULE: c = (a <= b);
			default: c = (a < b);
		endcase
		case (head.mode)
			OP_ADD:   x = head.l + head.r;
			OP_SUB:   x = head.l - head.r;
			OP_NEG:   x = 64'd0 - head.l;
			OP_AND:   x = head.l & head.r;
			OP_OR:    x = head.l | head.r;
			OP_XOR:   x = head.l ^ head.r;
			OP_SAR:   x = 64'($signed(src) >>> sh);
			OP_SHR:   x = (head.wide ? head.l : head.l & LOW32) >> sh;
			OP_SHL:   x = head.l << sh;
			OP_EXTSB: x = {{56{head.l[7]}}, head.l[7:0]};
			OP_EXTUB: x = {56'd0, head.l[7:0]};
			OP_EXTSH: x = {{48{head.l[15]}}, head.l[15:0]};
			OP_EXTUH: x = {48'd0, head.l[15:0]};
			OP_EXTSW: x = sext32(head.l);
			OP_EXTUW: x = head.l & LOW32;
			OP_CAST:  x = head.l;
			OP_CEQ, OP_CNE, OP_CSGE, OP_CSGT, OP_CSLE, OP_CSLT,
			OP_CUGE, OP_CUGT, OP_CULE, OP_CULT: x = {63'd0, c};
			default:  x = '0;
		endcase
		if (!head.wide) begin
			x = x & LOW32;
		end
		simple.cannot_fold = head.fail;
		simple.result_value = head.fail ? '0 : x;
		simple.result_is_addr = head.raddr;
		simple.result_symbol = head.rsym;
		is_mul = !head.fail && (head.mode == OP_MUL);
		is_div = !head.fail && (head.mode inside {OP_DIV, OP_REM, OP_UDIV, OP_UREM});
	end

	assign mul_res = (mul_lo_q + {mul_x1_q + mul_x2_q, 32'd0}) & (mul_wide_q ? '1 : LOW32);

	assign trial = {rem_q, quo_q[63]} - {1'b0, dvs_q};

	always_comb begin
		div_res = div_rem_q ? (div_negr_q ? 64'd0 - rem_q : rem_q)
			: (div_negq_q ? 64'd0 - quo_q : quo_q);
		if (!div_wide_q) begin
			div_res = div_res & LOW32;
		end
	end

	assign out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		load_out = 1'b0;
		load_mul = 1'b0;
		load_div = 1'b0;
		out_d = simple;
		case (state_q)
			BK_RUN: begin
				if (head_valid) begin
					if (is_mul) begin
						pop = 1'b1;
						load_mul = 1'b1;
						state_d = BK_MUL;
					end else if (is_div) begin
						pop = 1'b1;
						load_div = 1'b1;
						state_d = BK_DIV;
					end else if (out_free) begin
						pop = 1'b1;
						load_out = 1'b1;
					end
				end
			end
			BK_MUL: begin
				out_d = '{cannot_fold: 1'b0, result_value: mul_res,
					result_is_addr: 1'b0, result_symbol: '0};
				if (out_free) begin
					load_out = 1'b1;
					state_d = BK_RUN;
				end
			end
			BK_DIV: begin
				if (cnt_q == CntW'(1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				out_d = '{cannot_fold: 1'b0, result_value: div_res,
					result_is_addr: 1'b0, result_symbol: '0};
				if (out_free) begin
					load_out = 1'b1;
					state_d = BK_RUN;
				end
			end
			default: state_d = BK_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_RUN;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			if (load_div) begin
				cnt_q <= CntW'(DIV_STEPS);
			end else if (state_q == BK_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_d;
		end
		// low 64 bits of the product from three 32x32 partial products
		if (load_mul) begin
			mul_lo_q <= 64'(head.l[31:0] * head.r[31:0]);
			mul_x1_q <= 32'(head.l[31:0] * head.r[63:32]);
			mul_x2_q <= 32'(head.l[63:32] * head.r[31:0]);
			mul_wide_q <= head.wide;
		end
		if (load_div) begin
			rem_q <= '0;
			quo_q <= head.l;
			dvs_q <= head.r;
			div_rem_q <= (head.mode == OP_REM) || (head.mode == OP_UREM);
			div_negq_q <= head.neg_q;
			div_negr_q <= head.neg_r;
			div_wide_q <= head.wide;
		end else if (state_q == BK_DIV) begin
			// shift in one dividend bit, subtract when it fits
			if (!trial[64]) begin
				rem_q <= trial[63:0];
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
			end
			quo_q <= {quo_q[62:0], !trial[64]};
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

endmodule
`default_nettype wire

/* src/integer_constant_fold_alu_top.sv */
// Integer constant-fold ALU: front classifier, queue and execution back end.
// Depends on icf_pkg, icf_front, icf_queue and icf_back.
`timescale 1ns / 1ps
`default_nettype none
// Folds one integer operation on two constant operands, each plain bits or a
// symbol address plus offset, into one response word per request word, in
// order. Add, sub, neg, logic, shifts, extensions, cast and compares load the
// response register and flow at one per cycle unless the receiver stalls. Mul
// registers three 32x32 partial products, then sums them. Signed and unsigned
// div/rem use a radix-2 iterative divider and hold the back end for load, 64
// steps and write out; that divider sets the worst-case rate. Words that
// cannot fold (address misuse, divide by zero, signed MIN by -1, mode 31) load
// it too and return cannot_fold with all other fields zero. A two-word queue
// lets the front keep accepting while the back end works.
module integer_constant_fold_alu_top import icf_pkg::*; #(
	parameter int SYMBOL_ID_BITS = SYMBOL_ID_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	ent_t ent, head;
	logic full, nonempty, pop;

	icf_front #(.SYMBOL_ID_BITS(SYMBOL_ID_BITS)) u_front (
		.req(req),
		.ent(ent)
	);

	icf_queue #(.Depth(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(req_valid),
		.wdata(ent),
		.full(full),
		.pop(pop),
		.nonempty(nonempty),
		.rdata(head)
	);

	icf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(nonempty),
		.head(head),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	assign req_stall = full;

endmodule
`default_nettype wire

/* tb/sv/fold_checker.sv */
// Checker for the integer constant-fold ALU: watches both channels, predicts each
// response word from the request word and compares in order. Depends on icf_pkg.
`timescale 1ns / 1ps
module fold_checker import icf_pkg::*; (
	input  logic clk,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	input  logic finish_chk,
	output int   fail_count,
	output int   pending
);

	rsp_t expected_words[$];

	function automatic logic [63:0] sx32(input logic [63:0] v);
		logic [63:0] t;
		t = {{32{v[31]}}, v[31:0]};
		return t;
	endfunction

	function automatic logic [63:0] sdiv(input logic [63:0] a, input logic [63:0] b,
			input logic want_rem);
		logic [63:0] ua, ub, q, r;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		q = ua / ub;
		r = ua % ub;
		if (want_rem)
			return a[63] ? -r : r;
		return (a[63] != b[63]) ? -q : q;
	endfunction

	function automatic rsp_t fold(input req_t q);
		rsp_t o;
		logic fail, raddr, w, c;
		logic [31:0] ls, rs, rsym;
		logic [63:0] l, r, x, a, b, mw;
		int sh;
		w = q.wide;
		l = q.left_value;
		r = q.right_value;
		ls = q.left_symbol;
		rs = q.right_symbol;
		fail = 0; raddr = 0; rsym = 0; x = 0; c = 0;
		mw = w ? 64'hffff_ffff_ffff_ffff : LOW32;
		sh = w ? int'(r[5:0]) : int'(r[4:0]);
		if (q.mode == OP_ADD) begin
			if (q.left_is_addr && q.right_is_addr) fail = 1;
			else if (q.left_is_addr) begin raddr = 1; rsym = ls; end
			else if (q.right_is_addr) begin raddr = 1; rsym = rs; end
		end else if (q.mode == OP_SUB) begin
			if (q.left_is_addr) begin
				if (!q.right_is_addr) begin raddr = 1; rsym = ls; end
				else if (ls != rs) fail = 1;
			end else if (q.right_is_addr) fail = 1;
		end else if (q.left_is_addr || q.right_is_addr) fail = 1;
		if (!fail && q.mode >= OP_DIV && q.mode <= OP_UREM) begin
			if ((r & mw) == 0) fail = 1;
			else if ((q.mode == OP_DIV || q.mode == OP_REM) && (r & mw) == mw &&
					(l & mw) == (w ? SMIN64 : {32'd0, SMIN32})) fail = 1;
		end
		if (!fail) begin
			a = q.compare_long ? l : sx32(l);
			b = q.compare_long ? r : sx32(r);
			case (q.mode)
				OP_ADD: x = l + r;
				OP_SUB: x = l - r;
				OP_NEG: x = -l;
				OP_DIV: x = w ? sdiv(l, r, 0) : sdiv(sx32(l), sx32(r), 0);
				OP_REM: x = w ? sdiv(l, r, 1) : sdiv(sx32(l), sx32(r), 1);
				OP_UDIV: x = w ? l / r : (l & LOW32) / (r & LOW32);
				OP_UREM: x = w ? l % r : (l & LOW32) % (r & LOW32);
				OP_MUL: x = l * r;
				OP_AND: x = l & r;
				OP_OR: x = l | r;
				OP_XOR: x = l ^ r;
				OP_SAR: x = $unsigned($signed(w ? l : sx32(l)) >>> sh);
				OP_SHR: x = (w ? l : (l & LOW32)) >> sh;
				OP_SHL: x = l << sh;
				OP_EXTSB: x = {{56{l[7]}}, l[7:0]};
				OP_EXTUB: x = {56'd0, l[7:0]};
				OP_EXTSH: x = {{48{l[15]}}, l[15:0]};
				OP_EXTUH: x = {48'd0, l[15:0]};
				OP_EXTSW: x = sx32(l);
				OP_EXTUW: x = l & LOW32;
				OP_CAST: x = l;
				OP_NONE: fail = 1;
				default: begin
					case (q.mode)
						OP_CEQ: c = a == b;
						OP_CNE: c = a != b;
						OP_CSGE: c = !($signed(a) < $signed(b));
						OP_CSGT: c = $signed(b) < $signed(a);
						OP_CSLE: c = !($signed(b) < $signed(a));
						OP_CSLT: c = $signed(a) < $signed(b);
						OP_CUGE: c = a >= b;
						OP_CUGT: c = a > b;
						OP_CULE: c = a <= b;
						default: c = a < b;
					endcase
					x = {63'd0, c};
				end
			endcase
		end
		o = '0;
		if (fail) begin
			o.cannot_fold = 1;
		end else begin
			o.result_value = x & mw;
			o.result_is_addr = raddr;
			o.result_symbol = raddr ? rsym : 32'd0;
		end
		return o;
	endfunction

	assign pending = expected_words.size();

	always @(posedge clk) begin
		rsp_t e;
		int errs;
		errs = 0;
		if (req_valid && !req_stall)
			expected_words.push_back(fold(req));
		if (rsp_valid && !rsp_stall) begin
			if (expected_words.size() == 0) begin
				$error("response word with nothing expected");
				errs++;
			end else begin
				e = expected_words.pop_front();
				if (e.cannot_fold !== rsp.cannot_fold) begin
					$error("cannot_fold exp %0d got %0d", e.cannot_fold, rsp.cannot_fold);
					errs++;
				end
				if (e.result_value !== rsp.result_value) begin
					$error("result_value exp %h got %h", e.result_value, rsp.result_value);
					errs++;
				end
				if (e.result_is_addr !== rsp.result_is_addr) begin
					$error("result_is_addr exp %0d got %0d", e.result_is_addr,
						rsp.result_is_addr);
					errs++;
				end
				if (e.result_symbol !== rsp.result_symbol) begin
					$error("result_symbol exp %h got %h", e.result_symbol, rsp.result_symbol);
					errs++;
				end
			end
		end
		if (finish_chk && expected_words.size() != 0) begin
			$error("%0d expected words never arrived", expected_words.size());
			errs++;
		end
		if (errs != 0)
			fail_count <= fail_count + errs;
	end

endmodule

/* tb/sv/testbench.sv */
// Stimulus and verdict for the integer constant-fold ALU.
// Depends on icf_pkg, integer_constant_fold_alu_top and fold_checker.
`timescale 1ns / 1ps
module testbench;
	import icf_pkg::*;

	logic clk, arst_n, req_valid, req_stall, rsp_valid, rsp_stall, finish_chk;
	req_t req;
	rsp_t rsp;
	int fail_count, pending, send_idle, recv_idle, hold_cycles;
	longint cycles;

	integer_constant_fold_alu_top u_dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	fold_checker u_chk (
		.clk(clk), .req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.finish_chk(finish_chk), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: random stall, plus a long hold-off when asked
	initial begin
		rsp_stall = 1;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_stall <= 1;
				hold_cycles--;
			end else
				rsp_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	function automatic logic [63:0] pick_value();
		case ($urandom_range(7))
			0: return 64'd0;
			1: return 64'hffff_ffff_ffff_ffff;
			2: return SMIN64;
			3: return {32'd0, SMIN32};
			4: return 64'hffff_ffff;
			5: return {$urandom, $urandom} & 64'hff;
			6: return {{32{1'b1}}, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic req_t rand_word();
		req_t q;
		logic [31:0] s;
		q.mode = 5'($urandom_range(31));
		q.wide = 1'($urandom_range(1));
		q.compare_long = 1'($urandom_range(1));
		q.left_value = pick_value();
		q.right_value = pick_value();
		// addresses are mostly on add and sub, where they matter
		q.left_is_addr = ($urandom_range(99) < ((q.mode <= OP_SUB) ? 50 : 8));
		q.right_is_addr = ($urandom_range(99) < ((q.mode <= OP_SUB) ? 50 : 8));
		s = $urandom;
		q.left_symbol = $urandom_range(3) == 0 ? $urandom : s;
		q.right_symbol = $urandom_range(2) == 0 ? $urandom : s;
		if ($urandom_range(99) < 30) q.mode = 5'($urandom_range(OP_UREM, OP_DIV));
		return q;
	endfunction

	// hold valid between back-to-back words; drop it only while idling
	task automatic send_word(input req_t q);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 0;
			@(negedge clk);
		end
		req <= q;
		req_valid <= 1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_dir(input logic [4:0] m, input logic w, input logic [63:0] l,
			input logic [63:0] r, input logic la, input logic ra,
			input logic [31:0] ls, input logic [31:0] rs);
		req_t q;
		q = '{m, w, w, l, r, la, ra, ls, rs};
		send_word(q);
	endtask

	initial begin
		req_t q;
		arst_n = 0;
		req_valid = 0;
		req = '0;
		finish_chk = 0;
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: extremes, address rules, divide cases, unused opcode
		send_dir(OP_ADD, 1, '1, 64'd1, 1, 0, 32'h1234, 0);
		send_dir(OP_ADD, 0, '1, '1, 1, 1, 5, 5);
		send_dir(OP_SUB, 1, 64'd10, 64'd3, 1, 1, 7, 7);
		send_dir(OP_SUB, 1, 64'd10, 64'd3, 1, 1, 7, 8);
		send_dir(OP_SUB, 0, 64'd10, 64'd3, 0, 1, 0, 8);
		send_dir(OP_SUB, 0, 0, '1, 1, 0, '1, 0);
		send_dir(OP_CAST, 1, 64'd5, 0, 1, 0, 3, 0);
		send_dir(OP_DIV, 1, SMIN64, '1, 0, 0, 0, 0);
		send_dir(OP_REM, 0, {32'd0, SMIN32}, 64'h1_ffff_ffff, 0, 0, 0, 0);
		send_dir(OP_DIV, 0, 64'h5, 64'hffff_0000_0000, 0, 0, 0, 0);
		send_dir(OP_UREM, 1, 64'd5, 0, 0, 0, 0, 0);
		send_dir(OP_DIV, 1, -64'sd7, 64'd2, 0, 0, 0, 0);
		send_dir(OP_REM, 0, 64'hffff_fff9, 64'd2, 0, 0, 0, 0);
		send_dir(OP_UDIV, 1, '1, 64'd3, 0, 0, 0, 0);
		send_dir(OP_MUL, 1, '1, '1, 0, 0, 0, 0);
		send_dir(OP_SAR, 0, 64'h8000_0000, 64'd63, 0, 0, 0, 0);
		send_dir(OP_SAR, 1, SMIN64, 64'd127, 0, 0, 0, 0);
		send_dir(OP_SHL, 0, '1, 64'd33, 0, 0, 0, 0);
		send_dir(OP_SHR, 1, '1, 64'd65, 0, 0, 0, 0);
		send_dir(OP_EXTSB, 1, 64'h80, 0, 0, 0, 0, 0);
		send_dir(OP_EXTSH, 0, 64'h8000, 0, 0, 0, 0, 0);
		send_dir(OP_CSLT, 0, 64'h1_8000_0000, 64'd1, 0, 0, 0, 0);
		send_dir(OP_CULT, 1, 64'd1, SMIN64, 0, 0, 0, 0);
		send_dir(OP_NONE, 1, 0, 0, 0, 0, 0, 0);
		for (int m = 0; m < 32; m++) begin
			q = rand_word();
			q.mode = 5'(m);
			q.left_is_addr = 0;
			q.right_is_addr = 0;
			send_word(q);
		end
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 24 : (ph == 1) ? 67 : 0;
			recv_idle = (ph == 0) ? 67 : (ph == 1) ? 24 : 0;
			if (ph == 2) hold_cycles = 400;
			for (int i = 0; i < 200; i++)
				send_word(rand_word());
			req_valid <= 0;
			// pause until every word is back
			while (pending != 0) @(negedge clk);
		end
		repeat (150) @(negedge clk);
		finish_chk <= 1;
		@(negedge clk);
		finish_chk <= 0;
		@(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
